>>> src/fed_pkg.sv
package fed_pkg;

  localparam int MAX_DELAY_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DL_W       = 17;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [DL_W-1:0]   DL_RESET   = DL_W'(14400);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(29491);
  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(32768);

  // Q1.15 rounding
  localparam int FRAC_BITS = 15;

  // output buffer depth
  localparam int OUT_DEPTH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH = 2'd0,
    REG_FADE_GAIN    = 2'd1,
    REG_BYPASS       = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic issue;   // item enters the lane, read echo at addr
    logic write;   // item updates the store (not bypass)
    logic clear;   // clearing sweep writes zero at addr
  } lane_ctl_t;

endpackage

>>> src/fed_lane.sv
module fed_lane import fed_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int AW = $clog2(MAX_DELAY)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     ctl,
  input  logic [AW-1:0]                 addr,
  input  logic [GAIN_W-1:0]             gain,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          y_valid
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + GAIN_W + 1;

  logic signed [SB-1:0] mem [MAX_DELAY];
  logic signed [SB-1:0] rd_data;

  logic                 s1_valid;
  logic                 s1_write;
  logic [AW-1:0]        s1_addr;
  logic signed [SB-1:0] s1_x;

  logic                 s2_valid;
  logic                 s2_write;
  logic [AW-1:0]        s2_addr;
  logic signed [PW-1:0] s2_prod;

  logic                 s3_valid;
  logic [AW-1:0]        s3_addr;
  logic signed [SB-1:0] s3_val;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] s2_rnd;
  logic signed [SB-1:0] s2_val;
  logic signed [SB-1:0] echo;
  logic signed [SB:0]   sum;
  logic signed [SB-1:0] sat;
  logic signed [GAIN_W:0] gain_s;
  logic                 wen;
  logic [AW-1:0]        waddr;
  logic signed [SB-1:0] wdata;

  // round half up, floor shift
  assign s2_rnd = s2_prod + PW'(1 << (FRAC_BITS - 1));
  assign s2_val = s2_rnd[SB+FRAC_BITS-1:FRAC_BITS];

  // writes not yet visible in rd_data
  always_comb begin
    if (s2_valid && s2_write && (s2_addr == s1_addr)) begin
      echo = s2_val;
    end else if (s3_valid && (s3_addr == s1_addr)) begin
      echo = s3_val;
    end else begin
      echo = rd_data;
    end
  end

  assign sum = (SB+1)'(s1_x) + (SB+1)'(echo);

  always_comb begin
    if (sum[SB] != sum[SB-1]) begin
      sat = {sum[SB], {(SB-1){~sum[SB]}}};
    end else begin
      sat = sum[SB-1:0];
    end
  end

  assign y       = s1_write ? sat : s1_x;
  assign y_valid = s1_valid;
  assign gain_s  = {1'b0, gain};
  assign prod    = PW'(sat) * PW'(gain_s);

  assign wen   = ctl.clear || (s2_valid && s2_write);
  assign waddr = ctl.clear ? addr : s2_addr;
  assign wdata = ctl.clear ? '0 : s2_val;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_write;
    end
  end

  always_ff @(posedge clk) begin
    s1_write <= ctl.write;
    s1_addr  <= addr;
    s1_x     <= x;
    s2_write <= s1_write;
    s2_addr  <= s1_addr;
    s2_prod  <= prod;
    s3_addr  <= s2_addr;
    s3_val   <= s2_val;
  end

endmodule

>>> src/fed_merge.sv
module fed_merge import fed_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] left,
  input  logic [SAMPLE_BITS-1:0] right,
  output logic                   room,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_W-1:0]     m_axis_tdata   // left_out, right_out
);

  localparam int EW    = 2 * SAMPLE_BITS;
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [EW-1:0]    buf_mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = TDATA_W'(buf_mem[rd_ptr]);
  // an item in the lanes will land here next cycle
  assign room = ((CNT_W+1)'(count) + (CNT_W+1)'(push)) < (CNT_W+1)'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= {right, left};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

>>> src/feedback_echo_delay.sv
// Stereo feedback echo. Each s_axis item is one stereo frame; each m_axis item is the frame
// plus the echo read from the delay store, saturated, while the output scaled by fade_gain
// (Q1.15, rounded half up) is written back and the position advances modulo delay_length.
// Both channels run in their own lane with a private echo memory; a small output buffer joins
// them into one item. One frame is taken per clock unless clearing or room is low; frames
// pass a registered memory read and the buffer. Writes still in flight are forwarded, so
// delays of one or two samples work at full rate. After reset the echo memories are cleared
// one address per clock over MAX_DELAY addresses (65536 by default) with s_axis_tready low;
// configuration writes are taken at any time but must only be made while no frame is in
// flight. With bypass set frames pass unchanged and the echo state is held.
module feedback_echo_delay import fed_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // left_sample, right_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // left_out, right_out
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_DELAY);
  localparam int LEN_W = $clog2(MAX_DELAY + 1);
  localparam int CW    = (DL_W > LEN_W) ? DL_W : LEN_W;

  typedef logic [CW-1:0] cnt_t;

  logic [DL_W-1:0]   delay_length;
  logic [GAIN_W-1:0] fade_gain;
  logic              bypass;

  logic [AW-1:0]     pos;
  logic [AW-1:0]     pos_next;
  logic [AW-1:0]     pos_use;
  cnt_t              len_eff;
  cnt_t              pos_inc;
  logic [GAIN_W-1:0] gain_eff;

  logic              clearing;
  logic [AW-1:0]     clr_addr;

  logic              accept;
  logic              room;
  lane_ctl_t         ctl;
  logic [AW-1:0]     lane_addr;

  logic signed [SB-1:0] left_y;
  logic signed [SB-1:0] right_y;
  logic                 left_valid;
  logic                 right_valid;

  always_comb begin
    if (delay_length == '0) begin
      len_eff = cnt_t'(1);
    end else if (cnt_t'(delay_length) > cnt_t'(MAX_DELAY)) begin
      len_eff = cnt_t'(MAX_DELAY);
    end else begin
      len_eff = cnt_t'(delay_length);
    end
  end

  assign gain_eff = (fade_gain > GAIN_ONE) ? GAIN_ONE : fade_gain;

  // position left over from a longer delay restarts at zero
  assign pos_use  = (cnt_t'(pos) >= len_eff) ? '0 : pos;
  assign pos_inc  = cnt_t'(pos_use) + cnt_t'(1);
  assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];

  assign s_axis_tready = !clearing && room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctl.issue  = accept;
  assign ctl.write  = !bypass;
  assign ctl.clear  = clearing;
  assign lane_addr  = clearing ? clr_addr : pos_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= DL_RESET;
      fade_gain    <= GAIN_RESET;
      bypass       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_DELAY_LENGTH: delay_length <= cfg_data[DL_W-1:0];
        REG_FADE_GAIN:    fade_gain    <= cfg_data[GAIN_W-1:0];
        REG_BYPASS:       bypass       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (accept && !bypass) begin
        pos <= pos_next;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(MAX_DELAY - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  fed_lane #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (lane_addr),
    .gain    (gain_eff),
    .x       (s_axis_tdata[SB-1:0]),
    .y       (left_y),
    .y_valid (left_valid)
  );

  fed_lane #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (lane_addr),
    .gain    (gain_eff),
    .x       (s_axis_tdata[2*SB-1:SB]),
    .y       (right_y),
    .y_valid (right_valid)
  );

  fed_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (left_valid),
    .left          (left_y),
    .right         (right_y),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("item accepted during echo memory clear");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    left_valid == right_valid)
    else $error("stereo lanes out of step");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    accept && !bypass |=> cnt_t'(pos) < $past(len_eff))
    else $error("write position beyond delay length");

  a_bypass_holds_pos: assert property (@(posedge clk) disable iff (rst)
    accept && bypass |=> $stable(pos))
    else $error("position moved in bypass");

endmodule
